@@ src/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros; empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define FTS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FTS_ASSERT(lbl, clk, rst, prop, msg)
`define FTS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ src/fts_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Fenwick tree sum engine package
// Operation codes, phase descriptors and controller/datapath signal groups.
// ---------------------------------------------------------------------------
package fts_pkg;

   // Width of a walk index; holds top + 1 and the update walk overshoot.
   localparam int unsigned WALK_W = 12;

   localparam logic [2:0] OP_ADD    = 3'd0;
   localparam logic [2:0] OP_PREFIX = 3'd1;
   localparam logic [2:0] OP_RANGE  = 3'd2;
   localparam logic [2:0] OP_SUFFIX = 3'd3;
   localparam logic [2:0] OP_RADD   = 3'd4;
   localparam logic [2:0] OP_DADD   = 3'd5;
   localparam logic [2:0] OP_DSUM   = 3'd6;

   localparam logic [9:0] TREE_SIZE_RESET = 10'd1023;

   typedef enum logic [2:0] {
      IDX_LO   = 3'd0,
      IDX_LOM1 = 3'd1,
      IDX_HI   = 3'd2,
      IDX_HIP1 = 3'd3,
      IDX_TOP  = 3'd4
   } idx_sel_type;

   typedef enum logic {
      OPND_HI   = 1'b0,
      OPND_LOM1 = 1'b1
   } opnd_sel_type;

   // One phase of an operation: one tree walk plus optional multiply.
   typedef struct packed {
      logic         valid;
      logic         update;
      logic         aux;
      logic         neg;
      logic         mul;
      idx_sel_type  idx;
      opnd_sel_type opnd;
   } phase_type;

   typedef struct packed {
      logic      clear;
      logic      req_ready;
      logic      walk_start;
      logic      walk_run;
      logic      mul_go;
      logic      acc;
      logic      out_load;
      phase_type desc;
   } cmd_type;

   typedef struct packed {
      logic       accept;
      logic       clear_done;
      logic       walk_done;
      logic       rsp_free;
      logic       err;
      logic [2:0] op;
   } status_type;

   function automatic phase_type mk(input logic upd, input logic aux, input logic neg,
                                    input logic mul, input idx_sel_type idx,
                                    input opnd_sel_type opnd);
      phase_type d;
      d.valid  = 1'b1;
      d.update = upd;
      d.aux    = aux;
      d.neg    = neg;
      d.mul    = mul;
      d.idx    = idx;
      d.opnd   = opnd;
      return d;
   endfunction

   // Phase list of each operation; an invalid entry ends the operation.
   function automatic phase_type phase_desc(input logic [2:0] op, input logic [2:0] ph);
      phase_type d;
      d = '0;
      case (op)
         OP_ADD: begin
            if (ph == 3'd0) d = mk(1'b1, 1'b0, 1'b0, 1'b0, IDX_LO, OPND_HI);
         end
         OP_PREFIX: begin
            if (ph == 3'd0) d = mk(1'b0, 1'b0, 1'b0, 1'b0, IDX_LO, OPND_HI);
         end
         OP_RANGE: begin
            if (ph == 3'd0) d = mk(1'b0, 1'b0, 1'b0, 1'b0, IDX_HI, OPND_HI);
            if (ph == 3'd1) d = mk(1'b0, 1'b0, 1'b1, 1'b0, IDX_LOM1, OPND_HI);
         end
         OP_SUFFIX: begin
            if (ph == 3'd0) d = mk(1'b0, 1'b0, 1'b0, 1'b0, IDX_TOP, OPND_HI);
            if (ph == 3'd1) d = mk(1'b0, 1'b0, 1'b1, 1'b0, IDX_LOM1, OPND_HI);
         end
         OP_RADD: begin
            if (ph == 3'd0) d = mk(1'b1, 1'b0, 1'b0, 1'b0, IDX_LO, OPND_HI);
            if (ph == 3'd1) d = mk(1'b1, 1'b0, 1'b1, 1'b0, IDX_HIP1, OPND_HI);
         end
         OP_DADD: begin
            if (ph == 3'd0) d = mk(1'b1, 1'b0, 1'b0, 1'b0, IDX_LO, OPND_HI);
            if (ph == 3'd1) d = mk(1'b1, 1'b0, 1'b1, 1'b0, IDX_HIP1, OPND_HI);
            if (ph == 3'd2) d = mk(1'b1, 1'b1, 1'b0, 1'b1, IDX_LO, OPND_LOM1);
            if (ph == 3'd3) d = mk(1'b1, 1'b1, 1'b1, 1'b1, IDX_HIP1, OPND_HI);
         end
         OP_DSUM: begin
            if (ph == 3'd0) d = mk(1'b0, 1'b0, 1'b0, 1'b1, IDX_HI, OPND_HI);
            if (ph == 3'd1) d = mk(1'b0, 1'b1, 1'b1, 1'b0, IDX_HI, OPND_HI);
            if (ph == 3'd2) d = mk(1'b0, 1'b0, 1'b1, 1'b1, IDX_LOM1, OPND_LOM1);
            if (ph == 3'd3) d = mk(1'b0, 1'b1, 1'b0, 1'b0, IDX_LOM1, OPND_HI);
         end
         default: begin
            d = '0;
         end
      endcase
      return d;
   endfunction

endpackage

@@ src/fts_req_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Request channel interface
// Valid/ready channel carrying one operation transaction.
// ---------------------------------------------------------------------------
interface fts_req_if;
   logic               valid;
   logic               ready;
   logic        [2:0]  operation;
   logic        [10:0] index_low;
   logic        [10:0] index_high;
   logic signed [31:0] value;

   modport source (output valid, output operation, output index_low,
                   output index_high, output value, input ready);
   modport sink   (input valid, input operation, input index_low,
                   input index_high, input value, output ready);
endinterface

@@ src/fts_rsp_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Response channel interface
// Valid/ready channel carrying one result transaction.
// ---------------------------------------------------------------------------
interface fts_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] sum;
   logic               index_error;

   modport source (output valid, output sum, output index_error, input ready);
   modport sink   (input valid, input sum, input index_error, output ready);
endinterface

@@ src/fenwick_tree_sum_engine.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Fenwick tree sum engine
// Two binary indexed trees with point/range updates and prefix/range sums.
// ---------------------------------------------------------------------------
// Usage:
//   req_if carries one operation transaction (operation, index_low,
//   index_high, value); rsp_if returns exactly one result transaction
//   (sum, index_error) for each. csr_wr_en/csr_wr_data write tree_size.
//   One operation is processed at a time. Each phase walks one index chain
//   through a tree memory, one read per cycle with registered read data.
//   An out-of-range request or the unused operation code skips the walks
//   and goes straight to the result. The engine is ready again the cycle
//   after it loads the result. The next request is accepted while a result
//   waits in the output register; a stalled receiver holds the finished
//   result there, and the engine waits before delivering the following one.
//   After reset both trees are cleared one entry per cycle, all
//   MAX_INDEX + 1 entries, during which req_if.ready stays low.
// ---------------------------------------------------------------------------
module fenwick_tree_sum_engine #(
   parameter int unsigned MAX_INDEX = 1024
) (
   input  logic       clock,
   input  logic       reset,
   fts_req_if.sink    req_if,
   fts_rsp_if.source  rsp_if,
   input  logic       csr_wr_en,
   input  logic [9:0] csr_wr_data
);
   fts_pkg::cmd_type    cmd;
   fts_pkg::status_type status;

   // Sequencer.
   fts_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   // Trees, walker and arithmetic.
   fts_dp #(.MAX_INDEX(MAX_INDEX)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );
endmodule

@@ src/fts_ram.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module fts_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1025
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ src/fts_dp.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Fenwick tree datapath
// Request latch, tree walker, tree memories, multiplier and result register.
// ---------------------------------------------------------------------------
module fts_dp #(
   parameter int unsigned MAX_INDEX = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  fts_pkg::cmd_type    cmd,
   output fts_pkg::status_type status,
   fts_req_if.sink             req_if,
   fts_rsp_if.source           rsp_if,
   input  logic                csr_wr_en,
   input  logic [9:0]          csr_wr_data
);
   localparam int unsigned Depth = MAX_INDEX + 1;
   localparam int unsigned AddrW = $clog2(Depth);
   localparam int unsigned IW    = fts_pkg::WALK_W;

   logic [9:0]       tree_size_ff;
   logic [2:0]       op_ff;
   logic [10:0]      lo_ff, hi_ff;
   logic [31:0]      v_ff;
   logic [IW-1:0]    idx_ff, idx_in;
   logic [IW-1:0]    pend_addr_ff;
   logic             pend_ff;
   logic [31:0]      part_ff, delta_ff, prod_ff, res_ff;
   logic [AddrW-1:0] clr_cnt_ff;
   logic             rsp_valid_ff, rsp_err_ff;
   logic [31:0]      rsp_sum_ff;

   logic [10:0]   ts_p1, top;
   logic [IW-1:0] top_w, lo_w, lom1_w, hi_w, hip1_w, start_idx;
   logic          ranged, err, idx_ok, accept;
   logic [31:0]   opnd, mul_a, base, term, rdata, main_rd, aux_rd, wdata;
   logic          main_we, aux_we, rd_en;
   logic [AddrW-1:0] waddr, raddr;

   // Top tree index: tree_size + 1, capped at MAX_INDEX.
   assign ts_p1 = {1'b0, tree_size_ff} + 11'd1;
   assign top   = (32'(ts_p1) > MAX_INDEX) ? 11'(MAX_INDEX) : ts_p1;

   assign top_w  = {1'b0, top};
   assign lo_w   = {1'b0, lo_ff};
   assign hi_w   = {1'b0, hi_ff};
   assign lom1_w = (lo_ff == 11'd0) ? '0 : lo_w - 12'd1;
   assign hip1_w = hi_w + 12'd1;

   // Bounds check of the latched request.
   assign ranged = (op_ff == fts_pkg::OP_RANGE) || (op_ff == fts_pkg::OP_RADD) ||
                   (op_ff == fts_pkg::OP_DADD) || (op_ff == fts_pkg::OP_DSUM);
   assign err    = (op_ff <= fts_pkg::OP_DSUM) &&
                   ((lo_ff > top) || (ranged && ((hi_ff > top) || (lo_ff > hi_ff))));

   always_comb begin
      case (cmd.desc.idx)
         fts_pkg::IDX_LO:   start_idx = lo_w;
         fts_pkg::IDX_LOM1: start_idx = lom1_w;
         fts_pkg::IDX_HI:   start_idx = hi_w;
         fts_pkg::IDX_HIP1: start_idx = hip1_w;
         fts_pkg::IDX_TOP:  start_idx = top_w;
         default:           start_idx = '0;
      endcase
   end

   // Multiplier operands and the signed term of the current phase.
   assign opnd  = (cmd.desc.opnd == fts_pkg::OPND_HI) ? {21'd0, hi_ff}
                                                      : {21'd0, lo_ff} - 32'd1;
   assign mul_a = cmd.desc.update ? v_ff : part_ff;
   assign base  = cmd.desc.mul ? prod_ff : mul_a;
   assign term  = cmd.desc.neg ? (32'd0 - base) : base;

   // Walk stepping: the next index never depends on memory data.
   assign idx_ok = (idx_ff != '0) && (!cmd.desc.update || (idx_ff <= top_w));
   always_comb begin
      if (cmd.desc.update) begin
         idx_in = idx_ff + (idx_ff & (~idx_ff + 12'd1));
      end else begin
         idx_in = idx_ff & (idx_ff - 12'd1);
      end
   end

   assign accept = req_if.valid && cmd.req_ready;
   assign req_if.ready = cmd.req_ready;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         tree_size_ff <= fts_pkg::TREE_SIZE_RESET;
      end else if (csr_wr_en) begin
         tree_size_ff <= csr_wr_data;
      end
   end

   // Request latch.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= req_if.operation;
         lo_ff <= req_if.index_low;
         hi_ff <= req_if.index_high;
         v_ff  <= req_if.value;
      end
   end

   // Walk control.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         pend_ff <= 1'b0;
      end else if (accept) begin
         idx_ff  <= '0;
         pend_ff <= 1'b0;
      end else if (cmd.walk_start) begin
         idx_ff  <= start_idx;
         pend_ff <= 1'b0;
      end else if (cmd.walk_run) begin
         pend_ff <= idx_ok;
         if (idx_ok) begin
            idx_ff <= idx_in;
         end
      end
   end

   // Walk payload, multiplier and accumulators.
   always_ff @(posedge clock) begin
      if (cmd.walk_run && idx_ok) begin
         pend_addr_ff <= idx_ff;
      end
      if (cmd.walk_start) begin
         part_ff  <= '0;
         delta_ff <= term;
      end else if (pend_ff && !cmd.desc.update) begin
         part_ff <= part_ff + rdata;
      end
      if (cmd.mul_go) begin
         prod_ff <= mul_a * opnd;
      end
      if (accept) begin
         res_ff <= '0;
      end else if (cmd.acc) begin
         res_ff <= res_ff + term;
      end
   end

   // Clearing pass counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   // Tree memories share addresses; an update writes only the selected tree, the clearing pass both.
   assign rdata   = cmd.desc.aux ? aux_rd : main_rd;
   assign rd_en   = cmd.walk_run && idx_ok;
   assign raddr   = AddrW'(idx_ff);
   assign waddr   = cmd.clear ? clr_cnt_ff : AddrW'(pend_addr_ff);
   assign wdata   = cmd.clear ? '0 : rdata + delta_ff;
   assign main_we = cmd.clear || (pend_ff && cmd.desc.update && !cmd.desc.aux);
   assign aux_we  = cmd.clear || (pend_ff && cmd.desc.update && cmd.desc.aux);

   fts_ram #(.WIDTH(32), .DEPTH(Depth)) u_main_ram (
      .clock   (clock),
      .wr_en   (main_we),
      .wr_addr (waddr),
      .wr_data (wdata),
      .rd_en   (rd_en),
      .rd_addr (raddr),
      .rd_data (main_rd)
   );

   fts_ram #(.WIDTH(32), .DEPTH(Depth)) u_aux_ram (
      .clock   (clock),
      .wr_en   (aux_we),
      .wr_addr (waddr),
      .wr_data (wdata),
      .rd_en   (rd_en),
      .rd_addr (raddr),
      .rd_data (aux_rd)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_sum_ff <= err ? '0 : res_ff;
         rsp_err_ff <= err;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.sum         = rsp_sum_ff;
   assign rsp_if.index_error = rsp_err_ff;

   assign status.accept     = accept;
   assign status.clear_done = (clr_cnt_ff == AddrW'(Depth - 1));
   assign status.walk_done  = !idx_ok && !pend_ff;
   assign status.rsp_free   = !rsp_valid_ff || rsp_if.ready;
   assign status.err        = err;
   assign status.op         = op_ff;
endmodule

@@ src/fts_ctrl.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Fenwick tree controller
// Sequences the clearing pass and the phases of each operation.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module fts_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  fts_pkg::status_type status,
   output fts_pkg::cmd_type    cmd
);
   typedef enum logic [7:0] {
      S_CLEAR   = 8'b0000_0001,
      S_IDLE    = 8'b0000_0010,
      S_PHASE   = 8'b0000_0100,
      S_WSTART  = 8'b0000_1000,
      S_WALK    = 8'b0001_0000,
      S_POSTMUL = 8'b0010_0000,
      S_ACC     = 8'b0100_0000,
      S_FINISH  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [2:0] phase_ff, phase_in;
   fts_pkg::phase_type desc;

   assign desc = fts_pkg::phase_desc(status.op, phase_ff);

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      cmd      = '0;
      cmd.desc = desc;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            cmd.req_ready = 1'b1;
            if (status.accept) begin
               phase_in = '0;
               state_in = S_PHASE;
            end
         end
         S_PHASE: begin
            if (status.err || !desc.valid) begin
               state_in = S_FINISH;
            end else begin
               cmd.mul_go = desc.update && desc.mul;
               state_in   = S_WSTART;
            end
         end
         S_WSTART: begin
            cmd.walk_start = 1'b1;
            state_in       = S_WALK;
         end
         S_WALK: begin
            cmd.walk_run = 1'b1;
            if (status.walk_done) begin
               if (desc.update) begin
                  phase_in = phase_ff + 3'd1;
                  state_in = S_PHASE;
               end else if (desc.mul) begin
                  state_in = S_POSTMUL;
               end else begin
                  state_in = S_ACC;
               end
            end
         end
         S_POSTMUL: begin
            cmd.mul_go = 1'b1;
            state_in   = S_ACC;
         end
         S_ACC: begin
            cmd.acc  = 1'b1;
            phase_in = phase_ff + 3'd1;
            state_in = S_PHASE;
         end
         S_FINISH: begin
            if (status.rsp_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         phase_ff <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   // An accepted transaction always starts with its first phase.
   `FTS_ASSERT(a_accept_phase, clock, reset, status.accept |=> (state_ff == S_PHASE && phase_ff == 3'd0), "accept did not start phase zero")
   // A new walk only starts once the previous one has drained.
   `FTS_ASSERT(a_walk_drained, clock, reset, cmd.walk_start |-> status.walk_done, "walk started while busy")
   // No operation has more than four phases.
   `FTS_ASSERT(a_phase_bound, clock, reset, (state_ff == S_PHASE) |-> (phase_ff <= 3'd4), "phase count overrun")
endmodule

@@ test/fts_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Fenwick tree sum engine checker
// Watches the request and response channels, keeps its own copy of both
// trees and the size register, predicts each result and compares it.
// ---------------------------------------------------------------------------
module fts_checker #(
   parameter int unsigned MAX_INDEX = 1024
) (
   input  logic        clock,
   input  logic        reset,
   fts_req_if          req_mon,
   fts_rsp_if          rsp_mon,
   input  logic        csr_wr_en,
   input  logic [9:0]  csr_wr_data,
   output int          fail_count,
   output int          pending_count,
   output int          result_count
);

   typedef struct packed {
      logic [31:0] sum;
      logic        index_error;
   } sum_result_type;

   logic [31:0]    main_sums [0:MAX_INDEX];
   logic [31:0]    aux_sums [0:MAX_INDEX];
   logic [9:0]     size_reg;
   sum_result_type expected_sums [$];

   assign pending_count = expected_sums.size();

   function automatic logic [31:0] top_of_tree();
      logic [31:0] t;
      t = {22'd0, size_reg} + 32'd1;
      return (t > MAX_INDEX) ? MAX_INDEX : t;
   endfunction

   // Add along the update chain of one tree, stopping at the top index.
   task automatic chain_add(input bit use_aux, input logic [31:0] idx, input logic [31:0] v);
      logic [31:0] i;
      i = idx;
      while (i != 0 && i <= top_of_tree()) begin
         if (use_aux) aux_sums[i] += v;
         else main_sums[i] += v;
         i += i & (~i + 32'd1);
      end
   endtask

   function automatic logic [31:0] chain_prefix(input bit use_aux, input logic [31:0] idx);
      logic [31:0] s;
      logic [31:0] i;
      s = 0;
      i = (idx > top_of_tree()) ? top_of_tree() : idx;
      while (i != 0) begin
         s += use_aux ? aux_sums[i] : main_sums[i];
         i &= i - 32'd1;
      end
      return s;
   endfunction

   function automatic logic [31:0] range_prefix(input logic [31:0] x);
      return chain_prefix(1'b0, x) * x - chain_prefix(1'b1, x);
   endfunction

   // Predict the result of one operation and apply its updates.
   task automatic predict_sum(input logic [2:0] op, input logic [31:0] lo,
                              input logic [31:0] hi, input logic [31:0] v);
      sum_result_type r;
      logic [31:0]    top;
      bit             ranged;
      r = '0;
      top = top_of_tree();
      ranged = (op == fts_pkg::OP_RANGE || op == fts_pkg::OP_RADD ||
                op == fts_pkg::OP_DADD || op == fts_pkg::OP_DSUM);
      if (op <= fts_pkg::OP_DSUM && (lo > top || (ranged && (hi > top || lo > hi))))
         r.index_error = 1'b1;
      if (!r.index_error) begin
         case (op)
            fts_pkg::OP_ADD: chain_add(1'b0, lo, v);
            fts_pkg::OP_PREFIX: r.sum = chain_prefix(1'b0, lo);
            fts_pkg::OP_RANGE:
               r.sum = chain_prefix(1'b0, hi) - (lo != 0 ? chain_prefix(1'b0, lo - 1) : 0);
            fts_pkg::OP_SUFFIX:
               r.sum = chain_prefix(1'b0, top) - (lo != 0 ? chain_prefix(1'b0, lo - 1) : 0);
            fts_pkg::OP_RADD: begin
               chain_add(1'b0, lo, v);
               chain_add(1'b0, hi + 1, -v);
            end
            fts_pkg::OP_DADD: begin
               chain_add(1'b0, lo, v);
               chain_add(1'b0, hi + 1, -v);
               chain_add(1'b1, lo, v * (lo - 32'd1));
               chain_add(1'b1, hi + 1, -(v * hi));
            end
            fts_pkg::OP_DSUM:
               r.sum = range_prefix(hi) - (lo != 0 ? range_prefix(lo - 1) : 0);
            default: ;
         endcase
      end
      expected_sums.push_back(r);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("[%0t] MISMATCH %s: got %0h, expected %0h", $time, what, got, want);
      fail_count++;
   endtask

   // Track the size register, every accepted request and every response.
   always @(posedge clock) begin
      sum_result_type w;
      if (reset) begin
         size_reg <= fts_pkg::TREE_SIZE_RESET;
         for (int k = 0; k <= MAX_INDEX; k++) begin
            main_sums[k] = 0;
            aux_sums[k] = 0;
         end
      end else begin
         if (csr_wr_en) size_reg <= csr_wr_data;
         if (req_mon.valid && req_mon.ready)
            predict_sum(req_mon.operation, {21'd0, req_mon.index_low},
                        {21'd0, req_mon.index_high}, req_mon.value);
         if (rsp_mon.valid && rsp_mon.ready) begin
            result_count++;
            if (expected_sums.size() == 0) begin
               report_mismatch("unexpected transaction", rsp_mon.sum, 32'd0);
            end else begin
               w = expected_sums.pop_front();
               if (rsp_mon.sum !== w.sum) report_mismatch("sum", rsp_mon.sum, w.sum);
               if (rsp_mon.index_error !== w.index_error)
                  report_mismatch("index_error", {31'd0, rsp_mon.index_error},
                                  {31'd0, w.index_error});
            end
         end
      end
   end

   initial begin
      fail_count = 0;
      result_count = 0;
   end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Fenwick tree sum engine testbench
// Drives directed and random operations at several tree sizes with random
// gaps and response stalls; the checker predicts and compares every result.
// ---------------------------------------------------------------------------
module tb_top;

   localparam int WATCHDOG_LIMIT = 20000;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [9:0] csr_wr_data;
   int fail_count;
   int pending_count;
   int result_count;
   int idle_cycles;
   int sent_count;
   int top_now;
   bit long_stall;

   fts_req_if req_if ();
   fts_rsp_if rsp_if ();

   fenwick_tree_sum_engine i_dut (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   fts_checker i_checker (
      .clock(clock), .reset(reset), .req_mon(req_if), .rsp_mon(rsp_if),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data), .fail_count(fail_count),
      .pending_count(pending_count), .result_count(result_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: cycles with no transaction on either channel.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("fenwick_tree_sum_engine verification failed");
            $finish;
         end
      end
   end

   // Receiver: random stall per transaction, with stall-free stretches.
   initial begin
      int w;
      rsp_if.ready = 1'b0;
      @(posedge clock iff !reset);
      forever begin
         w = long_stall ? $urandom_range(0, 15) : 0;
         if (w > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (w) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock iff rsp_if.valid);
      end
   end

   // Valid stays high into the next transaction when there is no gap.
   task automatic send_op(input logic [2:0] op, input logic [10:0] lo,
                          input logic [10:0] hi, input logic [31:0] v);
      int w;
      w = long_stall ? $urandom_range(0, 15) : 0;
      if (w > 0) begin
         req_if.valid <= 1'b0;
         repeat (w) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.operation <= op;
      req_if.index_low <= lo;
      req_if.index_high <= hi;
      req_if.value <= v;
      @(posedge clock iff req_if.ready);
      sent_count++;
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_size(input logic [9:0] sz);
      drain_results();
      csr_wr_en <= 1'b1;
      csr_wr_data <= sz;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      top_now = sz + 1;
   endtask

   // Mostly in-range random operations with some out-of-range noise.
   task automatic random_ops(input int n);
      logic [2:0] op;
      logic [10:0] a;
      logic [10:0] b;
      logic [10:0] t;
      for (int k = 0; k < n; k++) begin
         long_stall = ($urandom_range(0, 7) != 0);
         op = 3'($urandom_range(0, 7));
         if ($urandom_range(0, 9) == 0) begin
            a = 11'($urandom);
            b = 11'($urandom);
         end else begin
            a = 11'($urandom_range(0, top_now));
            b = 11'($urandom_range(0, top_now));
            if (a > b && $urandom_range(0, 5) != 0) begin
               t = a;
               a = b;
               b = t;
            end
         end
         send_op(op, a, b, $urandom);
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_if.valid = 1'b0;
      req_if.operation = fts_pkg::OP_ADD;
      req_if.index_low = '0;
      req_if.index_high = '0;
      req_if.value = '0;
      long_stall = 1'b1;
      sent_count = 0;
      top_now = 1024;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, every operation and the error cases at reset size.
      send_op(fts_pkg::OP_ADD, 11'd1, 11'd0, 32'h7fffffff);
      send_op(fts_pkg::OP_ADD, 11'd1024, 11'd0, 32'h80000000);
      send_op(fts_pkg::OP_ADD, 11'd0, 11'd0, 32'hffffffff);
      send_op(fts_pkg::OP_PREFIX, 11'd0, 11'd0, 32'd0);
      send_op(fts_pkg::OP_PREFIX, 11'd1024, 11'd0, 32'd0);
      send_op(fts_pkg::OP_PREFIX, 11'd1025, 11'd0, 32'd0);
      send_op(fts_pkg::OP_PREFIX, 11'h7ff, 11'h7ff, 32'd0);
      send_op(fts_pkg::OP_RANGE, 11'd0, 11'd1024, 32'd0);
      send_op(fts_pkg::OP_RANGE, 11'd5, 11'd4, 32'd0);
      send_op(fts_pkg::OP_RANGE, 11'd3, 11'd1025, 32'd0);
      send_op(fts_pkg::OP_SUFFIX, 11'd0, 11'd0, 32'd0);
      send_op(fts_pkg::OP_SUFFIX, 11'd1024, 11'd0, 32'd0);
      send_op(fts_pkg::OP_RADD, 11'd2, 11'd1024, 32'd12345);
      send_op(fts_pkg::OP_RADD, 11'd0, 11'd7, 32'hdeadbeef);
      send_op(fts_pkg::OP_DADD, 11'd1, 11'd1024, 32'h55555555);
      send_op(fts_pkg::OP_DADD, 11'd0, 11'd0, 32'haaaaaaaa);
      send_op(fts_pkg::OP_DADD, 11'd9, 11'd3, 32'd1);
      send_op(fts_pkg::OP_DSUM, 11'd0, 11'd1024, 32'd0);
      send_op(fts_pkg::OP_DSUM, 11'd1, 11'd1, 32'd0);
      send_op(3'd7, 11'd1024, 11'd0, 32'hffffffff);

      // The sender holds off until every result is back.
      drain_results();
      random_ops(150);

      // A small size, then one in the middle, then the largest.
      write_size(10'd1);
      send_op(fts_pkg::OP_ADD, 11'd2, 11'd0, 32'd9);
      send_op(fts_pkg::OP_PREFIX, 11'd3, 11'd0, 32'd0);
      random_ops(150);
      write_size(10'd37);
      random_ops(150);
      write_size(10'd1023);
      random_ops(150);

      drain_results();
      $display("Sent %0d operations, checked %0d results at tree sizes 1023, 1, 37, 1023.",
               sent_count, result_count);
      if (fail_count == 0) begin
         $display("fenwick_tree_sum_engine verification clean");
      end else begin
         $display("fenwick_tree_sum_engine verification failed");
      end
      $finish;
   end

endmodule
